[hw/rtl/dmc_pkg.sv]
// Shared types, codes and helpers of the maze carver.
package dmc_pkg;

    // Default grid limits
    localparam int MAX_COLS_DEF = 64;
    localparam int MAX_ROWS_DEF = 64;

    // Path stack entry and row register widths (entries keep 24 bits of a cell index)
    localparam int STK_W = 24;
    localparam int ROW_W = STK_W - 1;
    // Width used to compare grid sizes against register values (values up to 511)
    localparam int CMP_W = 9;

    // Configuration port
    localparam int CFG_W  = 7;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] REG_START_COL   = 2'd2;
    localparam logic [1:0] REG_START_ROW   = 2'd3;

    // Function codes
    localparam logic [1:0] FUNC_INIT = 2'd0;
    localparam logic [1:0] FUNC_STEP = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    // Direction codes
    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    // Action codes (moves use the direction code)
    localparam logic [2:0] ACT_BACK     = 3'd4;
    localparam logic [2:0] ACT_FINISHED = 3'd5;
    localparam logic [2:0] ACT_ACK      = 3'd6;

    // Cell flags
    localparam logic [4:0] F_VISITED = 5'b10000;

    typedef struct packed {
        logic [1:0]  func;
        logic [1:0]  rand_pick;
        logic [11:0] cell_index;
    } t_in_item;

    typedef struct packed {
        logic [2:0] action;
        logic [5:0] pos_x;
        logic [5:0] pos_y;
        logic [4:0] cell_bits;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT_SWEEP,
        S_INIT_PUSH,
        S_STEP_IDX,
        S_RD_CUR,
        S_CUR_DATA,
        S_PROBE,
        S_NB_CHK,
        S_WR_CUR,
        S_WR_NB,
        S_AREA,
        S_POP_RD,
        S_DIV,
        S_READ_ADDR,
        S_READ_DATA,
        S_DONE
    } t_state;

    // Flag of the wall crossed when leaving in direction d
    function automatic logic [4:0] dir_flag(input logic [1:0] d);
        return 5'b00001 << d;
    endfunction

    // Flag of the same wall seen from the neighbor
    function automatic logic [4:0] opp_flag(input logic [1:0] d);
        return 5'b00001 << (d ^ 2'b01);
    endfunction

endpackage

[hw/rtl/dfs_maze_carver_unit.sv]
// Randomized depth-first maze carver: grid store, path stack and step sequencer.
//
// The block takes one transaction at a time and answers each with exactly one result.
// Init sweeps the whole cell store, one entry per cycle. A carve step that moves
// computes the cell index on the shared multiplier, reads the current cell, then probes
// the directions in turn (a blocked direction is skipped, an open one has its neighbor
// read from the cell store) and writes both cells back. A backtrack runs the bit-serial
// divider that turns the popped stack entry back into a column and a row. A result
// is held in S_DONE while the previous result is still waiting at the output.
module dfs_maze_carver_unit import dmc_pkg::*; #(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Item channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    // Result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int CELLS  = MAX_COLS * MAX_ROWS;
    localparam int IDX_W  = $clog2(CELLS);
    localparam int DEP_W  = $clog2(CELLS + 1);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int W_W    = $clog2(MAX_COLS + 1);
    localparam int H_W    = $clog2(MAX_ROWS + 1);
    localparam int CW1    = W_W + 1;
    localparam int RW1    = ROW_W + 1;
    localparam int MUL_W  = ROW_W + W_W;
    localparam int PROD_W = MUL_W + 1;

    // Configuration registers
    logic [CFG_W-1:0] r_grid_width;
    logic [CFG_W-1:0] r_grid_height;
    logic [CFG_W-1:0] r_start_col;
    logic [CFG_W-1:0] r_start_row;

    // Sequencer and walk state
    t_state           r_state;
    t_state           n_state;
    logic [DEP_W-1:0] r_depth;
    logic [COL_W-1:0] r_cur_col;
    logic [ROW_W-1:0] r_cur_row;
    logic [DEP_W-1:0] r_visited;

    // Per-transaction working registers
    logic [1:0]        r_func;
    logic [1:0]        r_pick;
    logic [11:0]       r_index;
    logic [PROD_W-1:0] r_cur_idx;
    logic              r_cur_oob;
    logic [4:0]        r_cur_bits;
    logic [PROD_W-1:0] r_nb_idx;
    logic              r_nb_oob;
    logic [4:0]        r_nb_bits;
    logic              r_rd_oob;
    logic [1:0]        r_k;
    logic [1:0]        r_dir;
    logic [IDX_W-1:0]  r_sw_idx;
    logic [COL_W-1:0]  r_sw_col;
    logic [H_W-1:0]    r_sw_row;
    logic [IDX_W-1:0]  r_start_idx;
    logic [2:0]        r_res_action;
    logic [4:0]        r_res_bits;

    // Output register
    logic      r_out_valid;
    t_out_item r_out_data;

    logic in_fire;
    logic cfg_wr;
    logic out_load;

    assign in_fire  = i_in_valid && o_in_ready;
    assign cfg_wr   = psel && penable && pwrite;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Effective grid sizes and start cell
    logic [W_W-1:0]   eff_w;
    logic [H_W-1:0]   eff_h;
    logic [COL_W-1:0] start_c;
    logic [H_W-1:0]   start_r;

    always_comb begin
        if (r_grid_width < CFG_W'(2)) begin
            eff_w = W_W'(2);
        end else if (CMP_W'(r_grid_width) > CMP_W'(MAX_COLS)) begin
            eff_w = W_W'(MAX_COLS);
        end else begin
            eff_w = W_W'(r_grid_width);
        end
        if (r_grid_height < CFG_W'(2)) begin
            eff_h = H_W'(2);
        end else if (CMP_W'(r_grid_height) > CMP_W'(MAX_ROWS)) begin
            eff_h = H_W'(MAX_ROWS);
        end else begin
            eff_h = H_W'(r_grid_height);
        end
        if (r_start_col == '0) begin
            start_c = '0;
        end else if (CMP_W'(r_start_col) > CMP_W'(eff_w)) begin
            start_c = COL_W'(eff_w - W_W'(1));
        end else begin
            start_c = COL_W'(r_start_col - CFG_W'(1));
        end
        if (r_start_row == '0) begin
            start_r = '0;
        end else if (CMP_W'(r_start_row) > CMP_W'(eff_h)) begin
            start_r = eff_h - H_W'(1);
        end else begin
            start_r = H_W'(r_start_row - CFG_W'(1));
        end
    end

    // Shared multiplier: cell index of the current position, or the grid area
    logic [ROW_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_p;
    logic [PROD_W-1:0] cur_idx_calc;

    assign mul_a        = (r_state == S_AREA) ? ROW_W'(eff_h) : r_cur_row;
    assign mul_p        = MUL_W'(mul_a) * MUL_W'(eff_w);
    assign cur_idx_calc = PROD_W'(mul_p) + PROD_W'(r_cur_col);

    // Memories
    logic             cell_we;
    logic [IDX_W-1:0] cell_waddr;
    logic [4:0]       cell_wdata;
    logic [IDX_W-1:0] cell_raddr;
    logic [4:0]       cell_rdata;
    logic             stk_we;
    logic [IDX_W-1:0] stk_waddr;
    logic [STK_W-1:0] stk_wdata;
    logic [IDX_W-1:0] stk_raddr;
    logic [STK_W-1:0] stk_rdata;

    dmc_ram #(
        .WIDTH (5),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (cell_waddr),
        .i_wdata (cell_wdata),
        .i_raddr (cell_raddr),
        .o_rdata (cell_rdata)
    );

    dmc_ram #(
        .WIDTH (STK_W),
        .DEPTH (CELLS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // Divider that splits a popped index into row and column
    logic             div_start;
    logic             div_done;
    logic [STK_W-1:0] div_quo;
    logic [W_W-1:0]   div_rem;

    dmc_divider #(
        .DVD_W (STK_W),
        .DVS_W (W_W)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (stk_rdata),
        .i_divisor   (eff_w),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // Direction probe: wall flag, grid bounds and neighbor index
    logic [1:0]        probe_dir;
    logic [3:0]        cur_dirs;
    logic              bound_ok;
    logic              probe_ok;
    logic [PROD_W-1:0] nb_idx_calc;
    logic [4:0]        nb_bits_now;
    logic              nb_free;

    assign probe_dir = r_pick + r_k;
    assign cur_dirs  = r_cur_bits[3:0];

    always_comb begin
        case (probe_dir)
            DIR_RIGHT: begin
                bound_ok    = (CW1'(r_cur_col) + CW1'(1)) < CW1'(eff_w);
                nb_idx_calc = r_cur_idx + PROD_W'(1);
            end
            DIR_LEFT: begin
                bound_ok    = (r_cur_col != '0) &&
                              ((CW1'(r_cur_col) - CW1'(1)) < CW1'(eff_w));
                nb_idx_calc = r_cur_idx - PROD_W'(1);
            end
            DIR_UP: begin
                bound_ok    = (r_cur_row != '0) &&
                              ((r_cur_row - ROW_W'(1)) < ROW_W'(eff_h));
                nb_idx_calc = r_cur_idx - PROD_W'(eff_w);
            end
            default: begin
                bound_ok    = (RW1'(r_cur_row) + RW1'(1)) < RW1'(eff_h);
                nb_idx_calc = r_cur_idx + PROD_W'(eff_w);
            end
        endcase
    end

    assign probe_ok    = !cur_dirs[probe_dir] && bound_ok;
    assign nb_bits_now = r_nb_oob ? '0 : cell_rdata;
    assign nb_free     = !nb_bits_now[4];

    // Backtrack decision
    logic             finish;
    logic [DEP_W-1:0] pop_addr;

    assign finish   = (PROD_W'(r_visited) >= PROD_W'(mul_p)) || (r_depth <= DEP_W'(1));
    assign pop_addr = r_depth - DEP_W'(2);

    // Init sweep: border flags, and the visited flag on the start cell, for cells inside the grid, zero beyond
    logic       sw_in_grid;
    logic       sw_is_start;
    logic       sw_last_col;
    logic [4:0] sw_val;

    assign sw_in_grid  = r_sw_row < eff_h;
    assign sw_is_start = (r_sw_col == start_c) && (r_sw_row == start_r);
    assign sw_last_col = CW1'(r_sw_col) == (CW1'(eff_w) - CW1'(1));
    assign sw_val      = sw_in_grid ? {sw_is_start,
                                       r_sw_row == (eff_h - H_W'(1)),
                                       r_sw_row == '0,
                                       r_sw_col == '0,
                                       sw_last_col} : '0;

    // Read-function address
    logic [PROD_W-1:0] read_addr;

    assign read_addr = PROD_W'(r_index);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    unique case (i_in_data.func)
                        FUNC_INIT: n_state = S_INIT_SWEEP;
                        FUNC_STEP: n_state = S_STEP_IDX;
                        FUNC_READ: n_state = S_READ_ADDR;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_INIT_SWEEP: begin
                if (r_sw_idx == IDX_W'(CELLS - 1)) begin
                    n_state = S_INIT_PUSH;
                end
            end
            S_INIT_PUSH: n_state = S_DONE;
            S_STEP_IDX:  n_state = S_RD_CUR;
            S_RD_CUR:    n_state = S_CUR_DATA;
            S_CUR_DATA:  n_state = S_PROBE;
            S_PROBE: begin
                if (probe_ok) begin
                    n_state = S_NB_CHK;
                end else if (r_k == 2'd3) begin
                    n_state = S_AREA;
                end
            end
            S_NB_CHK: begin
                if (nb_free) begin
                    n_state = S_WR_CUR;
                end else if (r_k == 2'd3) begin
                    n_state = S_AREA;
                end else begin
                    n_state = S_PROBE;
                end
            end
            S_WR_CUR: n_state = S_WR_NB;
            S_WR_NB:  n_state = S_DONE;
            S_AREA:   n_state = finish ? S_DONE : S_POP_RD;
            S_POP_RD: n_state = S_DIV;
            S_DIV: begin
                if (div_done) begin
                    n_state = S_DONE;
                end
            end
            S_READ_ADDR: n_state = S_READ_DATA;
            S_READ_DATA: n_state = S_DONE;
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory, divider and handshake controls
    always_comb begin
        o_in_ready = 1'b0;
        cell_we    = 1'b0;
        cell_waddr = r_cur_idx[IDX_W-1:0];
        cell_wdata = '0;
        cell_raddr = r_cur_idx[IDX_W-1:0];
        stk_we     = 1'b0;
        stk_waddr  = r_depth[IDX_W-1:0];
        stk_wdata  = r_nb_idx[STK_W-1:0];
        stk_raddr  = pop_addr[IDX_W-1:0];
        div_start  = 1'b0;
        unique case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_INIT_SWEEP: begin
                cell_we    = 1'b1;
                cell_waddr = r_sw_idx;
                cell_wdata = sw_val;
            end
            S_INIT_PUSH: begin
                stk_we    = 1'b1;
                stk_waddr = '0;
                stk_wdata = STK_W'(r_start_idx);
            end
            S_PROBE: cell_raddr = nb_idx_calc[IDX_W-1:0];
            S_WR_CUR: begin
                cell_we    = !r_cur_oob;
                cell_wdata = r_cur_bits | dir_flag(r_dir);
                stk_we     = r_depth < DEP_W'(CELLS);
            end
            S_WR_NB: begin
                cell_we    = !r_nb_oob;
                cell_waddr = r_nb_idx[IDX_W-1:0];
                cell_wdata = r_nb_bits | F_VISITED | opp_flag(r_dir);
            end
            S_POP_RD:    div_start  = 1'b1;
            S_READ_ADDR: cell_raddr = read_addr[IDX_W-1:0];
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_grid_width  <= CFG_W'(16);
            r_grid_height <= CFG_W'(16);
            r_start_col   <= CFG_W'(1);
            r_start_row   <= CFG_W'(1);
            r_depth       <= '0;
            r_cur_col     <= '0;
            r_cur_row     <= '0;
            r_visited     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            // Register writes
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_GRID_WIDTH:  r_grid_width  <= pwdata[CFG_W-1:0];
                    REG_GRID_HEIGHT: r_grid_height <= pwdata[CFG_W-1:0];
                    REG_START_COL:   r_start_col   <= pwdata[CFG_W-1:0];
                    REG_START_ROW:   r_start_row   <= pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end

            // Walk state
            case (r_state)
                S_INIT_PUSH: begin
                    r_depth   <= DEP_W'(1);
                    r_visited <= DEP_W'(1);
                    r_cur_col <= start_c;
                    r_cur_row <= ROW_W'(start_r);
                end
                S_WR_CUR: begin
                    case (r_dir)
                        DIR_RIGHT: r_cur_col <= r_cur_col + COL_W'(1);
                        DIR_LEFT:  r_cur_col <= r_cur_col - COL_W'(1);
                        DIR_UP:    r_cur_row <= r_cur_row - ROW_W'(1);
                        default:   r_cur_row <= r_cur_row + ROW_W'(1);
                    endcase
                    if (r_visited < DEP_W'(CELLS)) begin
                        r_visited <= r_visited + DEP_W'(1);
                    end
                    if (r_depth < DEP_W'(CELLS)) begin
                        r_depth <= r_depth + DEP_W'(1);
                    end
                end
                S_AREA: begin
                    if (!finish) begin
                        r_depth <= r_depth - DEP_W'(1);
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_cur_col <= COL_W'(div_rem);
                        r_cur_row <= ROW_W'(div_quo);
                    end
                end
                default: ;
            endcase

            // Output slot
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    r_func       <= i_in_data.func;
                    r_pick       <= i_in_data.rand_pick;
                    r_index      <= i_in_data.cell_index;
                    r_res_action <= ACT_ACK;
                    r_res_bits   <= '0;
                    r_k          <= '0;
                    r_sw_idx     <= '0;
                    r_sw_col     <= '0;
                    r_sw_row     <= '0;
                end
            end
            S_INIT_SWEEP: begin
                r_sw_idx <= r_sw_idx + IDX_W'(1);
                if (sw_last_col) begin
                    r_sw_col <= '0;
                    if (sw_in_grid) begin
                        r_sw_row <= r_sw_row + H_W'(1);
                    end
                end else begin
                    r_sw_col <= r_sw_col + COL_W'(1);
                end
                if (sw_in_grid && sw_is_start) begin
                    r_start_idx <= r_sw_idx;
                end
            end
            S_STEP_IDX: begin
                r_cur_idx <= cur_idx_calc;
                r_cur_oob <= cur_idx_calc >= PROD_W'(CELLS);
            end
            S_CUR_DATA: r_cur_bits <= r_cur_oob ? '0 : cell_rdata;
            S_PROBE: begin
                if (probe_ok) begin
                    r_nb_idx <= nb_idx_calc;
                    r_nb_oob <= nb_idx_calc >= PROD_W'(CELLS);
                    r_dir    <= probe_dir;
                end else begin
                    r_k <= r_k + 2'd1;
                end
            end
            S_NB_CHK: begin
                r_nb_bits <= nb_bits_now;
                if (!nb_free) begin
                    r_k <= r_k + 2'd1;
                end
            end
            S_WR_NB: r_res_action <= {1'b0, r_dir};
            S_AREA:  r_res_action <= finish ? ACT_FINISHED : ACT_BACK;
            S_READ_ADDR: r_rd_oob <= read_addr >= PROD_W'(CELLS);
            S_READ_DATA: r_res_bits <= r_rd_oob ? '0 : cell_rdata;
            default: ;
        endcase

        // Result payload
        if (out_load) begin
            r_out_data.action    <= r_res_action;
            r_out_data.pos_x     <= 6'(r_cur_col);
            r_out_data.pos_y     <= 6'(r_cur_row);
            r_out_data.cell_bits <= (r_func == FUNC_READ) ? r_res_bits : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Register read-back
    always_comb begin
        unique case (paddr[3:2])
            REG_GRID_WIDTH:  prdata = DATA_W'(r_grid_width);
            REG_GRID_HEIGHT: prdata = DATA_W'(r_grid_height);
            REG_START_COL:   prdata = DATA_W'(r_start_col);
            REG_START_ROW:   prdata = DATA_W'(r_start_row);
            default:         prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Stack never grows past the store
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEP_W'(CELLS))
        else $error("path stack depth beyond store size");

    // Visited count saturates at the store size
    a_visited_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_visited <= DEP_W'(CELLS))
        else $error("visited count beyond store size");

    // Init leaves exactly the start cell on the stack
    a_init_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT_PUSH) |=> (r_depth == DEP_W'(1) && r_visited == DEP_W'(1)))
        else $error("init did not leave one stack entry and one visited cell");

    // Divider results only arrive while the sequencer waits for them
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the pop sequence");

    // While a pop reads the stack, at least one entry is left on it
    a_pop_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_RD) |-> (r_depth >= DEP_W'(1)))
        else $error("pop with an empty stack");

endmodule

[hw/rtl/dmc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/dmc_divider.sv]
// Restoring divider, one quotient bit per cycle.
module dmc_divider import dmc_pkg::*; #(
    parameter int DVD_W = STK_W,
    parameter int DVS_W = CMP_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient,
    output logic [DVS_W-1:0] o_remainder
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_div;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   diff;
    logic             ge;
    logic [DVS_W-1:0] n_rem;

    // Shift in the next dividend bit and try the subtraction
    assign rem_sh = {r_rem, r_quo[DVD_W-1]};
    assign diff   = rem_sh - {1'b0, r_div};
    assign ge     = rem_sh >= {1'b0, r_div};
    assign n_rem  = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits fill in from the bottom as dividend bits leave the top
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule
